// File: hdl/pursuit_heading_controller_assert.svh
// Assertion macros used by the checker of the pursuit heading controller.
`ifndef PURSUIT_HEADING_CONTROLLER_ASSERT_SVH
`define PURSUIT_HEADING_CONTROLLER_ASSERT_SVH

// check in the same cycle, outside reset
`define PHC_ASSERT_NOW(label, cond, check) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (check)) \
      else $error("phc assertion failed");

// check in the following cycle, outside reset
`define PHC_ASSERT_NEXT(label, cond, check) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (check)) \
      else $error("phc assertion failed");

// check in the cycle after reset is seen
`define PHC_ASSERT_RESET(label, check) \
   label: assert property (@(posedge clock) reset |=> (check)) \
      else $error("phc reset assertion failed");

`endif

// File: hdl/phc_pkg.sv
package phc_pkg;

   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int COORD_FRAC_BITS_DEF = 12;
   localparam int ATAN_ENTRIES        = 24;
   localparam int SQRT_STEPS          = 17;
   localparam int ZW                  = 34;
   localparam int VW                  = 34;

   localparam logic [31:0]        HALF_PI_Q30 = 32'd1686629713;
   localparam logic signed [15:0] PI_Q12      = 16'sd12868;

   localparam logic [1:0] REG_LINEAR_GAIN   = 2'd0;
   localparam logic [1:0] REG_ANGULAR_GAIN  = 2'd1;
   localparam logic [1:0] REG_STOP_DISTANCE = 2'd2;

   localparam logic [15:0] LINEAR_GAIN_RST   = 16'd6554;
   localparam logic [15:0] ANGULAR_GAIN_RST  = 16'd32768;
   localparam logic [16:0] STOP_DISTANCE_RST = 17'd3277;

   typedef logic [31:0] atan_tab_type [ATAN_ENTRIES];

   localparam atan_tab_type ATAN_Q30 = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   typedef struct packed {
      logic signed [ZW-1:0] z;
      logic [VW-1:0]        rem;
      logic [VW-1:0]        root;
      logic signed [15:0]   heading;
      logic                 zero;
   } side_type;

endpackage

// File: hdl/phc_if.sv
interface phc_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        leader_x;
   logic [15:0]        leader_y;
   logic [15:0]        follower_x;
   logic [15:0]        follower_y;
   logic signed [14:0] follower_heading;

   modport source (output valid, leader_x, leader_y, follower_x, follower_y,
                   follower_heading, input ready);
   modport sink (input valid, leader_x, leader_y, follower_x, follower_y,
                 follower_heading, output ready);
endinterface

interface phc_rsp_if;
   logic               valid;
   logic               ready;
   logic [16:0]        linear_speed;
   logic signed [15:0] turn_rate;
   logic [16:0]        distance;
   logic signed [15:0] heading_error;
   logic               stopped;

   modport source (output valid, linear_speed, turn_rate, distance, heading_error,
                   stopped, input ready);
   modport sink (input valid, linear_speed, turn_rate, distance, heading_error,
                 stopped, output ready);
endinterface

// File: hdl/pursuit_heading_controller.sv
// Channel   Dir  Handshake     Content
// req_bus   in   valid/ready   leader and follower positions, follower heading
// rsp_bus   out  valid/ready   speed, turn rate, distance, heading error, stopped
// csr_*     in   APB write     linear_gain, angular_gain, stop_distance
//
// One request per cycle unless rsp_bus stalls; a request passes the front register,
// the cells (at most one CORDIC rotation and one root digit each), fin and out regs.
// Reset is synchronous and clears all valid flags; gains return to their defaults.
// A stage holds only while its successor is full and stalled, so bubbles close up.
module pursuit_heading_controller #(
   parameter int CORDIC_STAGES   = phc_pkg::CORDIC_STAGES_DEF,
   parameter int COORD_FRAC_BITS = phc_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   phc_req_if.sink     req_bus,
   phc_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import phc_pkg::*;

   localparam int XW = COORD_FRAC_BITS + 20;
   localparam int NC = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

   logic [15:0] linear_gain_ff;
   logic [15:0] angular_gain_ff;
   logic [16:0] stop_distance_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_gain_ff   <= LINEAR_GAIN_RST;
         angular_gain_ff  <= ANGULAR_GAIN_RST;
         stop_distance_ff <= STOP_DISTANCE_RST;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_LINEAR_GAIN:   linear_gain_ff   <= csr_pwdata[15:0];
            REG_ANGULAR_GAIN:  angular_gain_ff  <= csr_pwdata[15:0];
            REG_STOP_DISTANCE: stop_distance_ff <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_LINEAR_GAIN:   csr_prdata = {16'd0, linear_gain_ff};
         REG_ANGULAR_GAIN:  csr_prdata = {16'd0, angular_gain_ff};
         REG_STOP_DISTANCE: csr_prdata = {15'd0, stop_distance_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // front stage: difference vector
   logic               front_load;
   logic               front_valid_ff;
   logic signed [16:0] dx_ff;
   logic signed [16:0] dy_ff;
   logic signed [15:0] heading_ff;
   logic [NC-1:0]      cell_load;
   logic [NC-1:0]      cell_valid;

   assign front_load    = !front_valid_ff || cell_load[0];
   assign req_bus.ready = front_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_load) begin
         front_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_load) begin
         dx_ff      <= $signed({1'b0, req_bus.leader_x}) - $signed({1'b0, req_bus.follower_x});
         dy_ff      <= $signed({1'b0, req_bus.leader_y}) - $signed({1'b0, req_bus.follower_y});
         heading_ff <= 16'(req_bus.follower_heading);
      end
   end

   // squares for the root, quadrant fold for the CORDIC
   logic signed [33:0]   dx_sq;
   logic signed [33:0]   dy_sq;
   logic signed [XW-1:0] dx_s;
   logic signed [XW-1:0] dy_s;
   logic signed [XW-1:0] x_pre;
   logic signed [XW-1:0] y_pre;
   side_type             side_pre;

   assign dx_sq = dx_ff * dx_ff;
   assign dy_sq = dy_ff * dy_ff;
   assign dx_s  = XW'(dx_ff) <<< COORD_FRAC_BITS;
   assign dy_s  = XW'(dy_ff) <<< COORD_FRAC_BITS;

   always_comb begin
      x_pre            = dx_s;
      y_pre            = dy_s;
      side_pre.z       = '0;
      side_pre.rem     = VW'(dx_sq) + VW'(dy_sq);
      side_pre.root    = '0;
      side_pre.heading = heading_ff;
      side_pre.zero    = (dx_ff == '0) && (dy_ff == '0);
      if (dx_ff[16]) begin
         if (!dy_ff[16]) begin
            x_pre      = dy_s;
            y_pre      = -dx_s;
            side_pre.z = ZW'(HALF_PI_Q30);
         end else begin
            x_pre      = -dy_s;
            y_pre      = dx_s;
            side_pre.z = -ZW'(HALF_PI_Q30);
         end
      end
   end

   logic signed [XW-1:0] cell_x [NC];
   logic signed [XW-1:0] cell_y [NC];
   side_type             cell_side [NC];
   logic                 post_ready;

   genvar k;
   generate
      for (k = 0; k < NC; k++) begin : g_cell
         logic                 vin;
         logic signed [XW-1:0] xin;
         logic signed [XW-1:0] yin;
         side_type             sin;

         if (k == 0) begin : g_first
            assign vin = front_valid_ff;
            assign xin = x_pre;
            assign yin = y_pre;
            assign sin = side_pre;
         end else begin : g_next
            assign vin = cell_valid[k-1];
            assign xin = cell_x[k-1];
            assign yin = cell_y[k-1];
            assign sin = cell_side[k-1];
         end

         if (k == NC - 1) begin : g_last_load
            assign cell_load[k] = !cell_valid[k] || post_ready;
         end else begin : g_mid_load
            assign cell_load[k] = !cell_valid[k] || cell_load[k+1];
         end

         phc_cell #(
            .XW        (XW),
            .IDX       (k),
            .DO_CORDIC (k < CORDIC_STAGES),
            .DO_SQRT   (k < SQRT_STEPS)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .load     (cell_load[k]),
            .valid_in (vin),
            .x_in     (xin),
            .y_in     (yin),
            .side_in  (sin),
            .valid_ff (cell_valid[k]),
            .x_ff     (cell_x[k]),
            .y_ff     (cell_y[k]),
            .side_ff  (cell_side[k])
         );
      end
   endgenerate

   phc_post u_post (
      .clock         (clock),
      .reset         (reset),
      .valid_in      (cell_valid[NC-1]),
      .side_in       (cell_side[NC-1]),
      .linear_gain   (linear_gain_ff),
      .angular_gain  (angular_gain_ff),
      .stop_distance (stop_distance_ff),
      .rsp_ready     (rsp_bus.ready),
      .load_fin      (post_ready),
      .rsp_valid     (rsp_bus.valid),
      .linear_speed  (rsp_bus.linear_speed),
      .turn_rate     (rsp_bus.turn_rate),
      .distance      (rsp_bus.distance),
      .heading_error (rsp_bus.heading_error),
      .stopped       (rsp_bus.stopped)
   );

endmodule

// File: hdl/phc_cell.sv
module phc_cell #(
   parameter int XW        = 32,
   parameter int IDX       = 0,
   parameter bit DO_CORDIC = 1'b1,
   parameter bit DO_SQRT   = 1'b1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    valid_in,
   input  logic signed [XW-1:0]    x_in,
   input  logic signed [XW-1:0]    y_in,
   input  phc_pkg::side_type       side_in,
   output logic                    valid_ff,
   output logic signed [XW-1:0]    x_ff,
   output logic signed [XW-1:0]    y_ff,
   output phc_pkg::side_type       side_ff
);
   import phc_pkg::*;

   localparam int                   SQ_POS    = DO_SQRT ? 2 * (SQRT_STEPS - 1 - IDX) : 0;
   localparam logic [VW-1:0]        SQ_BIT    = VW'(1) << SQ_POS;
   localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(ATAN_Q30[IDX]);

   logic signed [XW-1:0] x_sh;
   logic signed [XW-1:0] y_sh;
   logic signed [XW-1:0] x_in_nx;
   logic signed [XW-1:0] y_in_nx;
   logic [VW:0]          trial;
   side_type             side_in_nx;

   assign x_sh  = x_in >>> IDX;
   assign y_sh  = y_in >>> IDX;
   assign trial = {1'b0, side_in.root} + {1'b0, SQ_BIT};

   always_comb begin
      x_in_nx    = x_in;
      y_in_nx    = y_in;
      side_in_nx = side_in;
      if (DO_CORDIC) begin
         if (!y_in[XW-1]) begin
            x_in_nx      = x_in + y_sh;
            y_in_nx      = y_in - x_sh;
            side_in_nx.z = side_in.z + ATAN_STEP;
         end else begin
            x_in_nx      = x_in - y_sh;
            y_in_nx      = y_in + x_sh;
            side_in_nx.z = side_in.z - ATAN_STEP;
         end
      end
      if (DO_SQRT) begin
         if ({1'b0, side_in.rem} >= trial) begin
            side_in_nx.rem  = side_in.rem - trial[VW-1:0];
            side_in_nx.root = (side_in.root >> 1) + SQ_BIT;
         end else begin
            side_in_nx.root = side_in.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= x_in_nx;
         y_ff    <= y_in_nx;
         side_ff <= side_in_nx;
      end
   end

endmodule

// File: hdl/phc_post.sv
module phc_post (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_in,
   input  phc_pkg::side_type  side_in,
   input  logic [15:0]        linear_gain,
   input  logic [15:0]        angular_gain,
   input  logic [16:0]        stop_distance,
   input  logic               rsp_ready,
   output logic               load_fin,
   output logic               rsp_valid,
   output logic [16:0]        linear_speed,
   output logic signed [15:0] turn_rate,
   output logic [16:0]        distance,
   output logic signed [15:0] heading_error,
   output logic               stopped
);
   import phc_pkg::*;

   logic                 load_out;
   logic signed [ZW-1:0] z_rnd;
   logic signed [15:0]   bearing;
   logic signed [15:0]   err_in;
   logic [16:0]          dist_in;
   logic                 stop_in;

   logic                 fin_valid_ff;
   logic [16:0]          dist_ff;
   logic signed [15:0]   err_ff;
   logic                 stop_ff;

   logic [32:0]          spd_prod;
   logic [33:0]          spd_rnd;
   logic signed [32:0]   trn_prod;
   logic signed [33:0]   trn_rnd;

   logic                 out_valid_ff;
   logic [16:0]          speed_ff;
   logic signed [15:0]   turn_ff;
   logic [16:0]          dist_out_ff;
   logic signed [15:0]   err_out_ff;
   logic                 stop_out_ff;

   assign load_out = !out_valid_ff || rsp_ready;
   assign load_fin = !fin_valid_ff || load_out;

   // round the angle to Q3.12 and clamp to plus or minus pi
   assign z_rnd = side_in.z + ZW'(131072);

   always_comb begin
      bearing = z_rnd[ZW-1:18];
      if (side_in.zero) begin
         bearing = '0;
      end else if (bearing > PI_Q12) begin
         bearing = PI_Q12;
      end else if (bearing < -PI_Q12) begin
         bearing = -PI_Q12;
      end
   end

   assign err_in  = bearing - side_in.heading;
   assign dist_in = side_in.root[16:0];
   assign stop_in = dist_in < stop_distance;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (load_fin) begin
         fin_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_fin) begin
         dist_ff <= dist_in;
         err_ff  <= err_in;
         stop_ff <= stop_in;
      end
   end

   assign spd_prod = linear_gain * dist_ff;
   assign spd_rnd  = {1'b0, spd_prod} + 34'd32768;
   assign trn_prod = $signed({1'b0, angular_gain}) * err_ff;
   assign trn_rnd  = 34'(trn_prod) + 34'sd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         speed_ff    <= stop_ff ? '0 : spd_rnd[32:16];
         turn_ff     <= trn_rnd[31:16];
         dist_out_ff <= dist_ff;
         err_out_ff  <= err_ff;
         stop_out_ff <= stop_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign linear_speed  = speed_ff;
   assign turn_rate     = turn_ff;
   assign distance      = dist_out_ff;
   assign heading_error = err_out_ff;
   assign stopped       = stop_out_ff;

endmodule

// File: hdl/phc_checker.sv
`include "pursuit_heading_controller_assert.svh"

module phc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [16:0]        rsp_linear_speed,
   input logic signed [15:0] rsp_turn_rate,
   input logic signed [15:0] rsp_heading_error,
   input logic               rsp_stopped
);

   `PHC_ASSERT_NOW(a_stop_no_speed, rsp_valid && rsp_stopped, rsp_linear_speed == 17'd0)
   `PHC_ASSERT_NOW(a_no_error_no_turn, rsp_valid && (rsp_heading_error == 16'sd0), rsp_turn_rate == 16'sd0)
   `PHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_linear_speed) && $stable(rsp_turn_rate))
   `PHC_ASSERT_RESET(a_reset_empty, !rsp_valid)

endmodule

bind pursuit_heading_controller phc_checker u_phc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_linear_speed  (rsp_bus.linear_speed),
   .rsp_turn_rate     (rsp_bus.turn_rate),
   .rsp_heading_error (rsp_bus.heading_error),
   .rsp_stopped       (rsp_bus.stopped)
);
